/* sv/gvns_pkg.sv */
`timescale 1ns / 1ps

package gvns_pkg;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int WORD_W   = 3 * COORD_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CROSS_W  = 50;
    localparam int MAG_W    = CROSS_W - 1;
    localparam int NRM_W    = 30;
    localparam int MUL_W    = 31;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_IN_W  = 64;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int DIV_NUM_W = NRM_W + 16;
    localparam int DIV_DEN_W = SQ_OUT_W + 1;
    localparam int DIV_REM_W = DIV_DEN_W + 1;
    localparam int Q_W      = 16;
    localparam int ACC_W    = 18;
    localparam int POS_W    = 32;
    localparam int NORM_W   = 16;
    localparam int RADIUS_W = 23;
    localparam int HT_W     = 34;
    localparam int TEX_W    = 8;

    // Ports
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 168;

    // Reset values of the registers
    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1 << 20);

    // Height thresholds: ht*1000 > K is the same as ht > floor(K/1000)
    localparam longint HT_ROCK  = (200 * (longint'(1) << 20)) / 1000;
    localparam longint HT_GRASS = -(((40 * (longint'(1) << 20)) + 999) / 1000);
    localparam longint HT_SAND  = -(((50 * (longint'(1) << 20)) + 999) / 1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS     = 3'd0,
        CFG_OUTWARD    = 3'd1,
        CFG_WATER_MODE = 3'd2,
        CFG_ORIGIN_X   = 3'd3,
        CFG_ORIGIN_Y   = 3'd4,
        CFG_ORIGIN_Z   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLS_ROCK  = 2'd0,
        CLS_GRASS = 2'd1,
        CLS_SAND  = 2'd2,
        CLS_DIRT  = 2'd3
    } colour_t;

endpackage

/* sv/gvns_ram.sv */
`timescale 1ns / 1ps

module gvns_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 70
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one registered entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/gvns_sqrt.sv */
`timescale 1ns / 1ps

module gvns_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [gvns_pkg::SQ_IN_W-1:0]   radicand,
    output logic                           busy,
    output logic                           done,
    output logic [gvns_pkg::SQ_OUT_W-1:0]  root
);

    localparam int REM_W = gvns_pkg::SQ_OUT_W + 2;
    localparam int CNT_W = $clog2(gvns_pkg::SQ_OUT_W);

    logic [gvns_pkg::SQ_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [gvns_pkg::SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [REM_W+1:0] rem_try;
    logic [REM_W+1:0] trial;
    logic             fits;

    // One result bit per cycle: bring down two radicand bits, test 4r+1
    assign rem_try = {rem_reg, rad_reg[gvns_pkg::SQ_IN_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = (rem_try >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= fits ? REM_W'(rem_try - trial) : REM_W'(rem_try);
                root_reg <= {root_reg[gvns_pkg::SQ_OUT_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(gvns_pkg::SQ_OUT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

/* sv/grid_vertex_normal_shader.sv */
`timescale 1ns / 1ps
// Surface grid to vertex converter.
// Feed the (SAMPLES+3)^2 points of a grid in raster order on the s_ channel
// (tdata: coord_x, coord_y, coord_z). Each interior point leaves as one vertex
// on the m_ channel one row later, when the point below it arrives.
// Border points and the points of the first two rows are only stored, and the
// block stays ready for the next point. A vertex-producing item is worked out
// with the shared shift-subtract divider (twelve divides per vertex) and the
// shared square-root unit (five roots per vertex).
// A zero cross product skips its divides and shortens the item.
// One item is worked on at a time; the next is taken as soon as the block is
// back in idle, also while the previous vertex still waits in the output
// register for the receiver. When the receiver stalls, the next vertex waits
// for the output register to drain.
// Reset clears the row and column counters and loads the register defaults;
// the line stores are not cleared, each entry is written before it is read.
// Configuration on cfg_we/cfg_addr/cfg_data must be written by the user only while idle; the block lacks a check.
module grid_vertex_normal_shader #(
    parameter int SAMPLES = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // coord_x[23:0], coord_y[47:24], coord_z[71:48]
    input  logic [gvns_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], norm_x[111:96], norm_y[127:112],
    // norm_z[143:128], colour_class[145:144], tex_u[153:146], tex_v[161:154]
    output logic [gvns_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [gvns_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [gvns_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int GRID_DIM = SAMPLES + 3;
    localparam int CNT_W    = $clog2(GRID_DIM);
    localparam int DEPTH    = 2 * GRID_DIM;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = gvns_pkg::COORD_W;

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_READ  = 16'b0000_0000_0000_0010,
        S_DIFF  = 16'b0000_0000_0000_0100,
        S_XM1   = 16'b0000_0000_0000_1000,
        S_XM2   = 16'b0000_0000_0001_0000,
        S_XM3   = 16'b0000_0000_0010_0000,
        S_NORM  = 16'b0000_0000_0100_0000,
        S_SQM   = 16'b0000_0000_1000_0000,
        S_SQA   = 16'b0000_0001_0000_0000,
        S_SQRT  = 16'b0000_0010_0000_0000,
        S_DIV   = 16'b0000_0100_0000_0000,
        S_DIVA  = 16'b0000_1000_0000_0000,
        S_PM    = 16'b0001_0000_0000_0000,
        S_PA    = 16'b0010_0000_0000_0000,
        S_PSQRT = 16'b0100_0000_0000_0000,
        S_FIN   = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [gvns_pkg::RADIUS_W-1:0]  radius_reg;
    logic                           outward_reg;
    logic                           water_reg;
    logic signed [gvns_pkg::POS_W-1:0] origin_reg [3];

    // Grid position
    logic [CNT_W-1:0] row_reg, col_reg;
    logic [CNT_W-1:0] row_next, col_next;
    logic             is_vertex;
    logic [AW-1:0]    slot_now, cen_now;
    logic             in_accept;

    // Item state
    logic [AW-1:0]                 slot_reg, cen_reg;
    logic [gvns_pkg::TEX_W-1:0]    tex_u_reg, tex_v_reg;
    logic                          last_reg;
    logic [gvns_pkg::WORD_W-1:0]   e_reg, w_raw, n_raw, p_raw, s_raw;
    logic [2:0]                    rd_cnt;

    // Line store
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [gvns_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;

    // Arithmetic
    logic signed [gvns_pkg::DIFF_W-1:0]  d_reg [4][3];
    logic [1:0]                          ci_reg, j_reg, k_reg;
    logic [1:0]                          cn, j1, j2;
    logic signed [gvns_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [gvns_pkg::PROD_W-1:0]  prod_next, prod_reg;
    logic signed [gvns_pkg::CROSS_W-1:0] c1_reg, c_val;
    logic [gvns_pkg::MAG_W-1:0]          m_reg [3];
    logic                                sgn_reg [3];
    logic                                too_big;
    logic [gvns_pkg::SQ_IN_W-1:0]        sum_reg;
    logic                                sq_start_reg;
    logic                                sq_busy, sq_done;
    logic [gvns_pkg::SQ_OUT_W-1:0]       sq_root;
    logic [gvns_pkg::SQ_OUT_W-1:0]       len_reg;
    logic [gvns_pkg::DIV_NUM_W-1:0]      num_reg;
    logic [gvns_pkg::DIV_DEN_W-1:0]      den_reg;
    logic [gvns_pkg::DIV_REM_W-1:0]      rem_reg, rem_try;
    logic                                div_fits;
    logic [gvns_pkg::Q_W-1:0]            q_reg;
    logic [5:0]                          div_cnt;
    logic signed [gvns_pkg::ACC_W-1:0]   acc_reg [3];
    logic signed [gvns_pkg::ACC_W-1:0]   q_signed;

    // Output register
    logic                                m_valid_reg;
    logic [gvns_pkg::OUT_TDATA_W-1:0]    m_data_reg;
    logic                                m_last_reg;
    logic                                out_free;
    logic [gvns_pkg::OUT_TDATA_W-1:0]    out_word;

    function automatic logic signed [CW-1:0] coord(input logic [gvns_pkg::WORD_W-1:0] w,
                                                   input int c);
        return $signed(w[c*CW +: CW]);
    endfunction

    function automatic logic [gvns_pkg::POS_W-1:0] sat_pos(
        input logic signed [CW-1:0] p, input logic signed [gvns_pkg::POS_W-1:0] o);
        logic signed [gvns_pkg::POS_W:0] s;
        s = (gvns_pkg::POS_W+1)'(p) + (gvns_pkg::POS_W+1)'(o);
        if (s > $signed(33'sh0_7FFF_FFFF)) return 32'h7FFF_FFFF;
        else if (s < $signed(-33'sh0_8000_0000)) return 32'h8000_0000;
        else return s[gvns_pkg::POS_W-1:0];
    endfunction

    function automatic logic [gvns_pkg::NORM_W-1:0] mean_norm(
        input logic signed [gvns_pkg::ACC_W-1:0] a, input logic outward);
        logic [gvns_pkg::ACC_W-1:0]  mag;
        logic [gvns_pkg::NORM_W-1:0] q;
        mag = a[gvns_pkg::ACC_W-1] ? gvns_pkg::ACC_W'(-a) : gvns_pkg::ACC_W'(a);
        q   = gvns_pkg::NORM_W'((mag + gvns_pkg::ACC_W'(2)) >> 2);
        return (a[gvns_pkg::ACC_W-1] ^ ~outward) ? -q : q;
    endfunction

    // Accept and grid position
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign is_vertex = (row_reg >= CNT_W'(2)) && (col_reg >= CNT_W'(1))
                       && (col_reg <= CNT_W'(GRID_DIM - 2));
    assign slot_now  = row_reg[0] ? AW'(GRID_DIM) + AW'(col_reg) : AW'(col_reg);
    assign cen_now   = row_reg[0] ? AW'(col_reg) : AW'(GRID_DIM) + AW'(col_reg);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg + 1'b1;
        if (col_reg == CNT_W'(GRID_DIM - 1)) begin
            col_next = '0;
            row_next = (row_reg == CNT_W'(GRID_DIM - 1)) ? '0 : row_reg + 1'b1;
        end
    end

    // Line store port: write a plain point at once, a vertex point after its reads
    assign ram_we    = (in_accept && !is_vertex) || (state_reg == S_DIFF);
    assign ram_waddr = in_accept ? slot_now : slot_reg;
    assign ram_wdata = in_accept ? s_tdata[gvns_pkg::WORD_W-1:0] : e_reg;

    always_comb begin
        case (rd_cnt)
            3'd0:    ram_raddr = slot_reg;
            3'd1:    ram_raddr = cen_reg - 1'b1;
            3'd2:    ram_raddr = cen_reg;
            default: ram_raddr = cen_reg + 1'b1;
        endcase
    end

    gvns_ram #(
        .WIDTH (gvns_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared multiplier operands
    assign cn = ci_reg + 1'b1;
    assign j1 = (j_reg == 2'd2) ? 2'd0 : j_reg + 1'b1;
    assign j2 = (j_reg == 2'd0) ? 2'd2 : j_reg - 1'b1;

    always_comb begin
        case (state_reg)
            S_XM1: begin
                mul_a = gvns_pkg::MUL_W'(d_reg[ci_reg][j1]);
                mul_b = gvns_pkg::MUL_W'(d_reg[cn][j2]);
            end
            S_XM2: begin
                mul_a = gvns_pkg::MUL_W'(d_reg[ci_reg][j2]);
                mul_b = gvns_pkg::MUL_W'(d_reg[cn][j1]);
            end
            S_SQM: begin
                mul_a = $signed({1'b0, m_reg[k_reg][gvns_pkg::NRM_W-1:0]});
                mul_b = $signed({1'b0, m_reg[k_reg][gvns_pkg::NRM_W-1:0]});
            end
            default: begin
                mul_a = gvns_pkg::MUL_W'(coord(p_raw, int'(k_reg)));
                mul_b = gvns_pkg::MUL_W'(coord(p_raw, int'(k_reg)));
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign c_val     = c1_reg - gvns_pkg::CROSS_W'(prod_reg);
    assign too_big   = (|m_reg[0][gvns_pkg::MAG_W-1:gvns_pkg::NRM_W])
                     | (|m_reg[1][gvns_pkg::MAG_W-1:gvns_pkg::NRM_W])
                     | (|m_reg[2][gvns_pkg::MAG_W-1:gvns_pkg::NRM_W]);

    // Divider step and setup for component k
    assign rem_try  = {rem_reg[gvns_pkg::DIV_REM_W-2:0], num_reg[gvns_pkg::DIV_NUM_W-1]};
    assign div_fits = ({1'b0, rem_try} >= {2'b00, den_reg});
    assign q_signed = sgn_reg[k_reg] ? -gvns_pkg::ACC_W'(q_reg) : gvns_pkg::ACC_W'(q_reg);

    gvns_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start_reg),
        .radicand (sum_reg),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_accept && is_vertex) state_next = S_READ;
            S_READ:  if (rd_cnt == 3'd4) state_next = S_DIFF;
            S_DIFF:  state_next = S_XM1;
            S_XM1:   state_next = S_XM2;
            S_XM2:   state_next = S_XM3;
            S_XM3:   state_next = (j_reg == 2'd2) ? S_NORM : S_XM1;
            S_NORM:  if (!too_big) state_next = S_SQM;
            S_SQM:   state_next = S_SQA;
            S_SQA:   state_next = (k_reg == 2'd2) ? S_SQRT : S_SQM;
            S_SQRT: begin
                if (sq_done) begin
                    if (sq_root != '0) state_next = S_DIV;
                    else state_next = (ci_reg == 2'd3) ? S_PM : S_XM1;
                end
            end
            S_DIV:   if (div_cnt == 6'(gvns_pkg::DIV_NUM_W - 1)) state_next = S_DIVA;
            S_DIVA: begin
                if (k_reg != 2'd2) state_next = S_DIV;
                else state_next = (ci_reg == 2'd3) ? S_PM : S_XM1;
            end
            S_PM:    state_next = S_PA;
            S_PA:    state_next = (k_reg == 2'd2) ? S_PSQRT : S_PM;
            S_PSQRT: if (sq_done) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            sq_start_reg <= 1'b0;
            radius_reg   <= gvns_pkg::RADIUS_RST;
            outward_reg  <= 1'b1;
            water_reg    <= 1'b0;
            for (int c = 0; c < 3; c++) origin_reg[c] <= '0;
        end else begin
            state_reg    <= state_next;
            sq_start_reg <= ((state_reg == S_SQA) || (state_reg == S_PA)) && (k_reg == 2'd2);
            if (in_accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    gvns_pkg::CFG_RADIUS:     radius_reg <= cfg_data[gvns_pkg::RADIUS_W-1:0];
                    gvns_pkg::CFG_OUTWARD:    outward_reg <= cfg_data[0];
                    gvns_pkg::CFG_WATER_MODE: water_reg <= cfg_data[0];
                    gvns_pkg::CFG_ORIGIN_X:   origin_reg[0] <= $signed(cfg_data);
                    gvns_pkg::CFG_ORIGIN_Y:   origin_reg[1] <= $signed(cfg_data);
                    gvns_pkg::CFG_ORIGIN_Z:   origin_reg[2] <= $signed(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    e_reg     <= s_tdata[gvns_pkg::WORD_W-1:0];
                    slot_reg  <= slot_now;
                    cen_reg   <= cen_now;
                    tex_u_reg <= gvns_pkg::TEX_W'(row_reg - CNT_W'(2));
                    tex_v_reg <= gvns_pkg::TEX_W'(col_reg - CNT_W'(1));
                    last_reg  <= (row_reg == CNT_W'(GRID_DIM - 1))
                                 && (col_reg == CNT_W'(GRID_DIM - 2));
                    rd_cnt    <= '0;
                end
            end
            S_READ: begin
                rd_cnt <= rd_cnt + 1'b1;
                case (rd_cnt)
                    3'd1:    w_raw <= ram_rdata;
                    3'd2:    n_raw <= ram_rdata;
                    3'd3:    p_raw <= ram_rdata;
                    3'd4:    s_raw <= ram_rdata;
                    default: ;
                endcase
            end
            S_DIFF: begin
                for (int c = 0; c < 3; c++) begin
                    d_reg[0][c] <= gvns_pkg::DIFF_W'(coord(n_raw, c))
                                 - gvns_pkg::DIFF_W'(coord(p_raw, c));
                    d_reg[1][c] <= gvns_pkg::DIFF_W'(coord(w_raw, c))
                                 - gvns_pkg::DIFF_W'(coord(p_raw, c));
                    d_reg[2][c] <= gvns_pkg::DIFF_W'(coord(s_raw, c))
                                 - gvns_pkg::DIFF_W'(coord(p_raw, c));
                    d_reg[3][c] <= gvns_pkg::DIFF_W'(coord(e_reg, c))
                                 - gvns_pkg::DIFF_W'(coord(p_raw, c));
                    acc_reg[c]  <= '0;
                end
                ci_reg <= '0;
                j_reg  <= '0;
            end
            S_XM2: c1_reg <= gvns_pkg::CROSS_W'(prod_reg);
            S_XM3: begin
                sgn_reg[j_reg] <= c_val[gvns_pkg::CROSS_W-1];
                m_reg[j_reg]   <= c_val[gvns_pkg::CROSS_W-1]
                                  ? gvns_pkg::MAG_W'(-c_val) : gvns_pkg::MAG_W'(c_val);
                j_reg   <= (j_reg == 2'd2) ? 2'd0 : j_reg + 1'b1;
                k_reg   <= '0;
                sum_reg <= '0;
            end
            S_NORM: begin
                // Halve all three until the largest fits in 30 bits
                if (too_big) begin
                    for (int c = 0; c < 3; c++) m_reg[c] <= m_reg[c] >> 1;
                end
            end
            S_SQA, S_PA: begin
                sum_reg <= sum_reg + gvns_pkg::SQ_IN_W'($unsigned(prod_reg));
                if (k_reg != 2'd2) k_reg <= k_reg + 1'b1;
            end
            S_SQRT: begin
                if (sq_done) begin
                    len_reg <= sq_root;
                    k_reg   <= '0;
                    num_reg <= gvns_pkg::DIV_NUM_W'(
                               {m_reg[0][gvns_pkg::NRM_W-1:0], 15'b0})
                             + gvns_pkg::DIV_NUM_W'(sq_root);
                    den_reg <= {sq_root, 1'b0};
                    rem_reg <= '0;
                    q_reg   <= '0;
                    div_cnt <= '0;
                    if (sq_root == '0) begin
                        ci_reg  <= ci_reg + 1'b1;
                        sum_reg <= '0;
                    end
                end
            end
            S_DIV: begin
                num_reg <= num_reg << 1;
                rem_reg <= div_fits ? rem_try - gvns_pkg::DIV_REM_W'(den_reg) : rem_try;
                q_reg   <= {q_reg[gvns_pkg::Q_W-2:0], div_fits};
                div_cnt <= div_cnt + 1'b1;
            end
            S_DIVA: begin
                // Fold the component in and set up the next one
                acc_reg[k_reg] <= acc_reg[k_reg] + q_signed;
                rem_reg <= '0;
                q_reg   <= '0;
                div_cnt <= '0;
                if (k_reg != 2'd2) begin
                    k_reg   <= k_reg + 1'b1;
                    num_reg <= gvns_pkg::DIV_NUM_W'(
                               {m_reg[k_reg + 1'b1][gvns_pkg::NRM_W-1:0], 15'b0})
                             + gvns_pkg::DIV_NUM_W'(len_reg);
                end else begin
                    k_reg   <= '0;
                    ci_reg  <= ci_reg + 1'b1;
                    sum_reg <= '0;
                end
            end
            S_PSQRT: if (sq_done) len_reg <= sq_root;
            default: ;
        endcase
    end

    // Vertex assembly
    always_comb begin
        logic signed [gvns_pkg::HT_W-1:0] ht;
        logic [1:0] cls;
        ht = $signed({2'b00, len_reg}) - $signed(gvns_pkg::HT_W'(radius_reg));
        if (!water_reg) cls = gvns_pkg::CLS_ROCK;
        else if (64'(ht) > gvns_pkg::HT_ROCK) cls = gvns_pkg::CLS_ROCK;
        else if (64'(ht) > gvns_pkg::HT_GRASS) cls = gvns_pkg::CLS_GRASS;
        else if (64'(ht) > gvns_pkg::HT_SAND) cls = gvns_pkg::CLS_SAND;
        else cls = gvns_pkg::CLS_DIRT;
        out_word = {6'b0, tex_v_reg, tex_u_reg, cls,
                    mean_norm(acc_reg[2], outward_reg),
                    mean_norm(acc_reg[1], outward_reg),
                    mean_norm(acc_reg[0], outward_reg),
                    sat_pos(coord(p_raw, 2), origin_reg[2]),
                    sat_pos(coord(p_raw, 1), origin_reg[1]),
                    sat_pos(coord(p_raw, 0), origin_reg[0])};
    end

    // Output register: hold until taken
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            m_data_reg <= out_word;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_grid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg < CNT_W'(GRID_DIM)) && (col_reg < CNT_W'(GRID_DIM)))
        else $error("grid counter out of range");

    a_vertex_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && is_vertex |=> state_reg == S_READ)
        else $error("vertex item did not start its reads");

    a_sqrt_free: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_start_reg |-> !sq_busy)
        else $error("square root started while busy");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> den_reg != '0)
        else $error("divide by zero length");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> state_reg != S_IDLE || $past(state_reg) != S_FIN
        || $past(m_data_reg) == m_data_reg)
        else $error("pending vertex overwritten");
`endif

endmodule

/* tb/tb_grid_vertex_normal_shader.sv */
`timescale 1ns / 1ps

module tb_grid_vertex_normal_shader;

    localparam int GRID   = 35;
    localparam int LIMIT  = 20000;
    localparam int SETTLE = 50;

    typedef enum int {PAT_SPHERE, PAT_NOISE, PAT_FLAT, PAT_EXTREME} pattern_t;

    typedef struct packed {
        logic [31:0] pos_x, pos_y, pos_z;
        logic [15:0] norm_x, norm_y, norm_z;
        logic [1:0]  cls;
        logic [7:0]  tex_u, tex_v;
        logic        last;
    } vertex_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [gvns_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [gvns_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_we = 0;
    logic [gvns_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [gvns_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    grid_vertex_normal_shader DUT (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    logic [gvns_pkg::IN_TDATA_W-1:0] point_q[$];
    vertex_t vertex_q[$];
    int errors = 0;
    int quiet_cycles = 0;
    bit steady = 0;

    // shadow of the block's registers and line stores
    longint radius_r = 1048576, ox = 0, oy = 0, oz = 0;
    bit outward_r = 1, water_r = 0;
    longint store_x[2*GRID], store_y[2*GRID], store_z[2*GRID];
    int row_c = 0, col_c = 0;

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // add the unit normal of a x b, in Q1.14, to acc
    function automatic void add_unit_normal(input longint a[3], input longint b[3],
                                            inout longint acc[3]);
        longint c[3], m[3], big, len, q;
        int s;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        big = 0;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = c[k] < 0 ? -c[k] : c[k];
            if (m[k] > big) big = m[k];
        end
        while ((big >> s) >= (longint'(1) << 30)) s++;
        for (int k = 0; k < 3; k++) m[k] = m[k] >> s;
        len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        if (len == 0) return;
        for (int k = 0; k < 3; k++) begin
            q = ((m[k] << 15) + len) / (2 * len);
            acc[k] += c[k] < 0 ? -q : q;
        end
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // advance the shadow grid by one point; queue the vertex it completes
    function automatic void shade_point(logic [gvns_pkg::IN_TDATA_W-1:0] d);
        longint e[3], w[3], p[3], n[3], s[3], wd[3], ed[3], acc[3], len, ht, q, mag;
        int slot, cb;
        vertex_t v;
        e[0] = longint'($signed(d[23:0]));
        e[1] = longint'($signed(d[47:24]));
        e[2] = longint'($signed(d[71:48]));
        slot = (row_c & 1) * GRID + col_c;
        cb = ((row_c + 1) & 1) * GRID;
        if (row_c >= 2 && col_c >= 1 && col_c <= GRID - 2) begin
            w = '{store_x[slot], store_y[slot], store_z[slot]};
            p = '{store_x[cb+col_c], store_y[cb+col_c], store_z[cb+col_c]};
            n = '{store_x[cb+col_c-1] - p[0], store_y[cb+col_c-1] - p[1],
                  store_z[cb+col_c-1] - p[2]};
            s = '{store_x[cb+col_c+1] - p[0], store_y[cb+col_c+1] - p[1],
                  store_z[cb+col_c+1] - p[2]};
            for (int k = 0; k < 3; k++) begin
                wd[k] = w[k] - p[k];
                ed[k] = e[k] - p[k];
                acc[k] = 0;
            end
            add_unit_normal(n, wd, acc);
            add_unit_normal(wd, s, acc);
            add_unit_normal(s, ed, acc);
            add_unit_normal(ed, n, acc);
            for (int k = 0; k < 3; k++) begin
                mag = acc[k] < 0 ? -acc[k] : acc[k];
                q = (mag + 2) >> 2;
                if (acc[k] < 0) q = -q;
                if (!outward_r) q = -q;
                acc[k] = q;
            end
            len = isqrt(p[0] * p[0] + p[1] * p[1] + p[2] * p[2]);
            ht = (len - radius_r) * 1000;
            if (!water_r || ht > (longint'(200) << 20)) v.cls = gvns_pkg::CLS_ROCK;
            else if (ht > -(longint'(40) << 20)) v.cls = gvns_pkg::CLS_GRASS;
            else if (ht > -(longint'(50) << 20)) v.cls = gvns_pkg::CLS_SAND;
            else v.cls = gvns_pkg::CLS_DIRT;
            v.pos_x = sat32(p[0] + ox);
            v.pos_y = sat32(p[1] + oy);
            v.pos_z = sat32(p[2] + oz);
            v.norm_x = acc[0][15:0];
            v.norm_y = acc[1][15:0];
            v.norm_z = acc[2][15:0];
            v.tex_u = 8'(row_c - 2);
            v.tex_v = 8'(col_c - 1);
            v.last = (row_c == GRID - 1 && col_c == GRID - 2);
            vertex_q.push_back(v);
        end
        store_x[slot] = e[0];
        store_y[slot] = e[1];
        store_z[slot] = e[2];
        col_c++;
        if (col_c >= GRID) begin
            col_c = 0;
            row_c++;
            if (row_c >= GRID) row_c = 0;
        end
    endfunction

    // feed points; predict on each accepted item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) shade_point(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (point_q.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
                    s_tdata <= point_q.pop_front();
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // check vertices against the oldest prediction
    always @(posedge aclk) begin
        vertex_t got, want;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 27);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[111:96],
                       m_tdata[127:112], m_tdata[143:128], m_tdata[145:144],
                       m_tdata[153:146], m_tdata[161:154], m_tlast};
                if (vertex_q.size() == 0) begin
                    $display("%0t unexpected vertex %h", $time, got);
                    errors++;
                end else begin
                    want = vertex_q.pop_front();
                    if (got !== want || m_tdata[167:162] !== '0) begin
                        $display("%0t vertex mismatch: expected %h actual %h",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    // stop when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (point_q.size() != 0 || s_tvalid || vertex_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(gvns_pkg::cfg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            gvns_pkg::CFG_RADIUS:     radius_r = longint'(val[22:0]);
            gvns_pkg::CFG_OUTWARD:    outward_r = val[0];
            gvns_pkg::CFG_WATER_MODE: water_r = val[0];
            gvns_pkg::CFG_ORIGIN_X:   ox = longint'($signed(val));
            gvns_pkg::CFG_ORIGIN_Y:   oy = longint'($signed(val));
            gvns_pkg::CFG_ORIGIN_Z:   oz = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [22:0] rad, bit outw, bit water,
                            logic [31:0] x0, logic [31:0] y0, logic [31:0] z0);
        write_reg(gvns_pkg::CFG_RADIUS, 32'(rad));
        write_reg(gvns_pkg::CFG_OUTWARD, 32'(outw));
        write_reg(gvns_pkg::CFG_WATER_MODE, 32'(water));
        write_reg(gvns_pkg::CFG_ORIGIN_X, x0);
        write_reg(gvns_pkg::CFG_ORIGIN_Y, y0);
        write_reg(gvns_pkg::CFG_ORIGIN_Z, z0);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic logic [23:0] pick_extreme();
        case ($urandom_range(3))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    int gen_r = 0, gen_c = 0;
    logic [gvns_pkg::IN_TDATA_W-1:0] flat_pt;

    // queue n grid points of the given shape, in raster order
    task automatic queue_points(pattern_t pat, int n);
        logic [23:0] x, y, z;
        repeat (n) begin
            if (pat == PAT_NOISE || (pat == PAT_SPHERE && $urandom_range(99) < 4)) begin
                x = 24'($urandom);
                y = 24'($urandom);
                z = 24'($urandom);
            end else if (pat == PAT_SPHERE) begin
                x = clamp24((gen_c - 17) * 4096 + int'($urandom_range(2047)) - 1024);
                y = clamp24((gen_r - 17) * 4096 + int'($urandom_range(2047)) - 1024);
                z = clamp24(radius_r + longint'($urandom_range(340000)) - 80000);
            end else if (pat == PAT_FLAT) begin
                {z, y, x} = flat_pt;
            end else begin
                x = pick_extreme();
                y = pick_extreme();
                z = pick_extreme();
            end
            point_q.push_back({z, y, x});
            gen_c++;
            if (gen_c >= GRID) begin
                gen_c = 0;
                gen_r = (gen_r + 1) % GRID;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // field extremes under the reset settings
        queue_points(PAT_EXTREME, 25);
        wait_drained();

        set_regs(23'd1048576, 1, 1, 32'd0, 32'd0, 32'd0);
        queue_points(PAT_SPHERE, 250);
        wait_drained();

        set_regs(23'd0, 0, 1, 32'h7FFFFFFF, 32'h80000000, 32'd0);
        queue_points(PAT_NOISE, 250);
        wait_drained();

        // full rate on both sides
        steady = 1;
        set_regs(23'h7FFFFF, 1, 1, -32'sd1048576, 32'h01000000, 32'd5);
        queue_points(PAT_SPHERE, 250);
        wait_drained();
        steady = 0;

        // coincident points give zero cross products
        flat_pt = gvns_pkg::IN_TDATA_W'({$urandom, $urandom, $urandom});
        set_regs(23'd2097152, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_points(PAT_FLAT, 250);
        wait_drained();

        set_regs(23'd3000000, 1, 1, 32'd0, 32'd0, 32'h80000000);
        queue_points(PAT_SPHERE, 250);
        wait_drained();

        set_regs(23'd123456, 0, 1, $urandom, $urandom, $urandom);
        queue_points(PAT_EXTREME, 250);
        wait_drained();

        set_regs(23'd1048576, 1, 1, 32'd0, 32'd0, 32'd0);
        queue_points(PAT_SPHERE, 250);
        wait_drained();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
